// ----- sv/tgss_pkg.sv -----
`default_nettype none

package tgss_pkg;

   localparam int STAMP_BITS = 64;
   localparam int VALUE_WORD_BITS = 32;

   // Configuration register indexes.
   localparam logic CSR_INTERVAL = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   localparam logic [STAMP_BITS-1:0] INTERVAL_RESET = 64'd1000000000;
   localparam logic [STAMP_BITS-1:0] OFFSET_RESET = 64'd0;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_MULTIPLY,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic                       req_type;
      logic [STAMP_BITS-1:0]      stamp;
      logic [VALUE_WORD_BITS-1:0] sample_value;
      logic                       value_present;
   } req_word_type;

   typedef struct packed {
      logic [STAMP_BITS-1:0]      snap_time;
      logic [VALUE_WORD_BITS-1:0] snap_value;
      logic                       snap_present;
   } rsp_word_type;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      op_type                     op;
      logic [STAMP_BITS-1:0]      stamp;
      logic [STAMP_BITS-1:0]      num;
      logic [VALUE_WORD_BITS-1:0] value;
      logic                       present;
   } entry_type;

endpackage

`default_nettype wire

// ----- sv/tgss_front.sv -----
`default_nettype none

module tgss_front
   import tgss_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_word_type          req_word,
   input  wire logic [STAMP_BITS-1:0] offset_ns,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output entry_type                  push_entry
);

   localparam int HELD_BITS = (VALUE_BITS < VALUE_WORD_BITS) ? VALUE_BITS : VALUE_WORD_BITS;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      take;

   // The stage takes a word when it is empty or its word leaves this cycle.
   assign req_ready = !valid_ff || push_ready;
   assign take = req_valid && req_ready;

   // Classify the word, mask the payload and form the dividend of the grid rounding.
   always_comb begin
      entry_in = entry_ff;
      if (take) begin
         entry_in.op = req_word.req_type ? OP_FLUSH : OP_SAMPLE;
         entry_in.stamp = req_word.stamp;
         entry_in.num = req_word.stamp - STAMP_BITS'(1) - offset_ns;
         entry_in.present = req_word.value_present;
         entry_in.value = req_word.value_present
            ? VALUE_WORD_BITS'(req_word.sample_value[HELD_BITS-1:0])
            : '0;
      end
   end

   assign valid_in = take || (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// ----- sv/tgss_queue.sv -----
`default_nettype none

module tgss_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;
   assign pop_data = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tgss_back.sv -----
`default_nettype none

module tgss_back
   import tgss_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [STAMP_BITS-1:0] interval_ns,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire entry_type             pop_entry,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_word
);

   localparam int HELD_BITS = (VALUE_BITS < VALUE_WORD_BITS) ? VALUE_BITS : VALUE_WORD_BITS;
   localparam int HALF_BITS = STAMP_BITS / 2;
   localparam int DIV_BITS = $clog2(STAMP_BITS);
   localparam logic [2:0] MUL_LAST = 3'd4;

   back_state_type        state_ff, state_in;
   logic [STAMP_BITS-1:0] boundary_ff, boundary_in;
   logic                  started_ff, started_in;
   logic [HELD_BITS-1:0]  held_value_ff, held_value_in;
   logic                  held_present_ff, held_present_in;
   logic [STAMP_BITS-1:0] cur_stamp_ff, cur_stamp_in;
   logic [HELD_BITS-1:0]  cur_value_ff, cur_value_in;
   logic                  cur_present_ff, cur_present_in;
   logic [STAMP_BITS-1:0] rem_ff, rem_in;
   logic [STAMP_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]   div_count_ff, div_count_in;
   logic [2:0]            mul_step_ff, mul_step_in;
   logic [STAMP_BITS-1:0] prod_ff, prod_in;
   logic [STAMP_BITS-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  slot_free, head_flush, head_inside, head_take, start_div;
   logic                  crossed, finish_go;
   logic [STAMP_BITS:0]   rem_shift, rem_diff;
   logic [HALF_BITS-1:0]  mult_a, mult_b;
   logic [STAMP_BITS-1:0] mult_result;

   // Decisions on the head of the queue and on the finished grid value.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign head_flush = pop_entry.op == OP_FLUSH;
   assign head_inside = started_ff && (pop_entry.stamp <= boundary_ff);
   assign pop_ready = (state_ff == BK_IDLE) && (!head_flush || !started_ff || slot_free);
   assign head_take = pop_valid && pop_ready;
   assign start_div = !head_flush && !head_inside;
   assign crossed = started_ff || (cur_stamp_ff > acc_ff);
   assign finish_go = !crossed || slot_free;

   // One restoring division step per cycle.
   assign rem_shift = {rem_ff, quo_ff[STAMP_BITS-1]};
   assign rem_diff = rem_shift - {1'b0, interval_ns};

   // Low half products of (quotient + 1) times the interval, one per cycle.
   always_comb begin
      mult_a = quo_ff[HALF_BITS-1:0];
      mult_b = interval_ns[HALF_BITS-1:0];
      if (mul_step_ff == 3'd2) begin
         mult_b = interval_ns[STAMP_BITS-1:HALF_BITS];
      end else if (mul_step_ff == 3'd3) begin
         mult_a = quo_ff[STAMP_BITS-1:HALF_BITS];
      end
   end

   assign mult_result = STAMP_BITS'(mult_a) * STAMP_BITS'(mult_b);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_take && start_div) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (div_count_ff == '0) begin
               state_in = BK_MULTIPLY;
            end
         end
         BK_MULTIPLY: begin
            if (mul_step_ff == MUL_LAST) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (finish_go) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Datapath and result register.
   always_comb begin
      boundary_in = boundary_ff;
      started_in = started_ff;
      held_value_in = held_value_ff;
      held_present_in = held_present_ff;
      cur_stamp_in = cur_stamp_ff;
      cur_value_in = cur_value_ff;
      cur_present_in = cur_present_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_count_in = div_count_ff;
      mul_step_in = mul_step_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in = rsp_word_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_take) begin
               priority if (head_flush) begin
                  // A flush sends the last snapshot and ends the stream.
                  if (started_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in.snap_time = boundary_ff;
                     rsp_word_in.snap_value = VALUE_WORD_BITS'(held_value_ff);
                     rsp_word_in.snap_present = held_present_ff;
                     boundary_in = '0;
                     started_in = 1'b0;
                     held_value_in = '0;
                     held_present_in = 1'b0;
                  end
               end else if (head_inside) begin
                  held_value_in = pop_entry.value[HELD_BITS-1:0];
                  held_present_in = pop_entry.present;
               end else begin
                  cur_stamp_in = pop_entry.stamp;
                  cur_value_in = pop_entry.value[HELD_BITS-1:0];
                  cur_present_in = pop_entry.present;
                  rem_in = '0;
                  quo_in = pop_entry.num;
                  div_count_in = DIV_BITS'(STAMP_BITS - 1);
                  mul_step_in = '0;
               end
            end
         end
         BK_DIVIDE: begin
            if (!rem_diff[STAMP_BITS]) begin
               rem_in = rem_diff[STAMP_BITS-1:0];
               quo_in = {quo_ff[STAMP_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[STAMP_BITS-1:0];
               quo_in = {quo_ff[STAMP_BITS-2:0], 1'b0};
            end
            div_count_in = div_count_ff - DIV_BITS'(1);
         end
         BK_MULTIPLY: begin
            mul_step_in = mul_step_ff + 3'd1;
            unique case (mul_step_ff)
               3'd0: quo_in = quo_ff + STAMP_BITS'(1);
               3'd1: prod_in = mult_result;
               3'd2: begin
                  acc_in = prod_ff;
                  prod_in = mult_result;
               end
               3'd3: begin
                  acc_in = acc_ff + {prod_ff[HALF_BITS-1:0], HALF_BITS'(0)};
                  prod_in = mult_result;
               end
               default: begin
                  acc_in = acc_ff + {prod_ff[HALF_BITS-1:0], HALF_BITS'(0)};
               end
            endcase
         end
         BK_FINISH: begin
            // The new boundary is in acc; a crossing sends the old snapshot first.
            if (finish_go) begin
               if (crossed) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in.snap_time = started_ff ? boundary_ff : acc_ff;
                  rsp_word_in.snap_value = VALUE_WORD_BITS'(held_value_ff);
                  rsp_word_in.snap_present = held_present_ff;
               end
               boundary_in = acc_ff;
               started_in = 1'b1;
               held_value_in = cur_value_ff;
               held_present_in = cur_present_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         boundary_ff <= '0;
         started_ff <= 1'b0;
         held_value_ff <= '0;
         held_present_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         boundary_ff <= boundary_in;
         started_ff <= started_in;
         held_value_ff <= held_value_in;
         held_present_ff <= held_present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_stamp_ff <= cur_stamp_in;
      cur_value_ff <= cur_value_in;
      cur_present_ff <= cur_present_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_count_ff <= div_count_in;
      mul_step_ff <= mul_step_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

`default_nettype wire

// ----- sv/time_grid_snapshot_sampler_core.sv -----
`default_nettype none
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  req_word: type, stamp, value, present
// rsp       out        rsp_valid/rsp_ready  rsp_word: snapshot time, value, present
// csr       in         csr_valid/csr_ready  csr_index, csr_data (interval, offset)
//
// In the back end, a sample at or before the current boundary, and a flush, are handled
// in the idle state. A crossing sample, and the first sample of a stream, go through the
// 64 steps of the serial divider, the 5 of the split 32-bit multiplier and a finish state.
// Reset clears the stream state and loads the register defaults.
// A two-word queue lets the front keep taking words while the back divides or the
// result register waits for rsp_ready.

module time_grid_snapshot_sampler_core
   import tgss_pkg::*;
#(
   parameter int VALUE_BITS = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_word_type               req_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_word_type                    rsp_word,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [STAMP_BITS-1:0]      csr_data
);

   logic [STAMP_BITS-1:0] interval_ff, interval_in;
   logic [STAMP_BITS-1:0] offset_ff, offset_in;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   entry_type             push_entry, pop_entry;
   logic [$bits(entry_type)-1:0] pop_data;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      interval_in = interval_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_in = csr_data;
            CSR_OFFSET:   offset_in = csr_data;
            default:      interval_in = interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         interval_ff <= interval_in;
         offset_ff <= offset_in;
      end
   end

   tgss_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .offset_ns(offset_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   tgss_queue #(
      .WIDTH($bits(entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_entry),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   assign pop_entry = entry_type'(pop_data);

   tgss_back #(
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .interval_ns(interval_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

endmodule

`default_nettype wire

// ----- test/tb_time_grid_snapshot_sampler_core.sv -----
`default_nettype none

module tb_time_grid_snapshot_sampler_core;
   import tgss_pkg::*;

   localparam logic [STAMP_BITS-1:0] MAX_STAMP = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam int PHASE_ITEMS = 175;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_INTERVAL;
   logic [STAMP_BITS-1:0] csr_data = '0;

   time_grid_snapshot_sampler_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Register copies and stream state of the sampler as predicted.
   logic [STAMP_BITS-1:0] interval_reg = INTERVAL_RESET;
   logic [STAMP_BITS-1:0] offset_reg = OFFSET_RESET;
   logic [STAMP_BITS-1:0] grid_mark = '0;
   logic stream_open = 1'b0;
   logic [VALUE_WORD_BITS-1:0] kept_value = '0;
   logic kept_present = 1'b0;

   req_word_type pending_words[$];
   rsp_word_type expected_snaps[$];

   bit req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int holds_started = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int words_sent = 0;
   int snaps_checked = 0;
   int reg_writes = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Boundary on the grid at or after a stamp less the offset; the offset is never added back.
   function automatic logic [STAMP_BITS-1:0] grid_boundary(input logic [STAMP_BITS-1:0] t);
      logic [STAMP_BITS-1:0] num;
      logic [STAMP_BITS-1:0] quot;
      num = (t - 64'd1) - offset_reg;
      quot = (interval_reg != '0) ? num / interval_reg : '1;
      return (quot + 64'd1) * interval_reg;
   endfunction

   // Advances the predicted stream by one word and tells whether a snapshot results.
   function automatic bit take_word(input req_word_type w, output rsp_word_type snap);
      bit emits;
      emits = 1'b0;
      snap.snap_time = grid_mark;
      snap.snap_value = kept_value;
      snap.snap_present = kept_present;
      if (w.req_type == OP_FLUSH) begin
         if (stream_open) begin
            emits = 1'b1;
            grid_mark = '0;
            stream_open = 1'b0;
            kept_value = '0;
            kept_present = 1'b0;
         end
      end else begin
         if (!stream_open) begin
            grid_mark = grid_boundary(w.stamp);
            stream_open = 1'b1;
            snap.snap_time = grid_mark;
         end
         if (w.stamp > grid_mark) begin
            emits = 1'b1;
            grid_mark = grid_boundary(w.stamp);
         end
         kept_present = w.value_present;
         kept_value = w.value_present ? w.sample_value : '0;
      end
      return emits;
   endfunction

   function automatic logic [STAMP_BITS-1:0] rand_stamp();
      logic [STAMP_BITS-1:0] t;
      t = {$urandom, $urandom};
      return (t > MAX_STAMP) ? MAX_STAMP : t;
   endfunction

   task automatic offer(input op_type op, input logic [STAMP_BITS-1:0] t,
                        input logic [VALUE_WORD_BITS-1:0] v, input logic p);
      req_word_type w;
      w.req_type = op;
      w.stamp = t;
      w.sample_value = v;
      w.value_present = p;
      pending_words.push_back(w);
   endtask

   // Input driver: a word stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus long hold-offs on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_started != holds_asked) begin
         holds_started = holds_started + 1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predicts on each taken word and checks each delivered snapshot.
   always @(posedge clock) begin
      rsp_word_type snap;
      rsp_word_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         words_sent++;
         if (take_word(req_word, snap)) begin
            expected_snaps.push_back(snap);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snaps.size() == 0) begin
            $error("snapshot at %h arrived with none expected", rsp_word.snap_time);
            mismatches++;
         end else begin
            want = expected_snaps.pop_front();
            snaps_checked++;
            if (rsp_word.snap_time !== want.snap_time) begin
               $error("snap_time expected %h actual %h", want.snap_time, rsp_word.snap_time);
               mismatches++;
            end
            if (rsp_word.snap_value !== want.snap_value) begin
               $error("snap_value expected %h actual %h", want.snap_value,
                      rsp_word.snap_value);
               mismatches++;
            end
            if (rsp_word.snap_present !== want.snap_present) begin
               $error("snap_present expected %b actual %b", want.snap_present,
                      rsp_word.snap_present);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Waits until every word is taken and every snapshot is back, then lets the
   // back end finish any word that produces no snapshot.
   task automatic drain();
      do @(posedge clock); while (pending_words.size() > 0 || req_valid);
      do @(posedge clock); while (expected_snaps.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [STAMP_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == CSR_INTERVAL) begin
         interval_reg = data;
      end else begin
         offset_reg = data;
      end
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One stream of non-decreasing stamps with random steps and stray words, mostly flushed.
   task automatic add_stream(output int added);
      logic [STAMP_BITS-1:0] t;
      logic [STAMP_BITS-1:0] step;
      logic [STAMP_BITS-1:0] nxt;
      int n;
      n = $urandom_range(1, 12);
      added = n;
      case ($urandom_range(3))
         0: t = $urandom_range(2000);
         1: t = rand_stamp();
         2: t = MAX_STAMP - $urandom_range(5000);
         default: t = interval_reg * $urandom_range(50) + $urandom_range(2) - 1;
      endcase
      if (t > MAX_STAMP) t = MAX_STAMP;
      for (int i = 0; i < n; i++) begin
         if (i > 0) begin
            case ($urandom_range(4))
               0: step = '0;
               1: step = $urandom_range(1, 3);
               2: step = interval_reg / $urandom_range(1, 8);
               3: step = interval_reg * $urandom_range(1, 3) + $urandom_range(2);
               default: step = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            nxt = t + step;
            if (nxt < t || nxt > MAX_STAMP) nxt = MAX_STAMP;
            t = nxt;
         end
         // Now and then a stray word: an out-of-order stamp or a lone flush.
         if ($urandom_range(24) == 0) begin
            offer(OP_SAMPLE, rand_stamp(), $urandom, $urandom_range(1));
         end else if ($urandom_range(39) == 0) begin
            offer(OP_FLUSH, rand_stamp(), $urandom, $urandom_range(1));
         end
         offer(OP_SAMPLE, t, $urandom, $urandom_range(9) != 0);
      end
      if ($urandom_range(9) != 0) begin
         offer(OP_FLUSH, rand_stamp(), $urandom, $urandom_range(1));
         added++;
      end
   endtask

   task automatic run_phase(input logic [STAMP_BITS-1:0] iv, input logic [STAMP_BITS-1:0] off,
                            input int send_pct, input int recv_pct, input bit long_hold,
                            input bit pause_midway);
      int generated;
      int n;
      bit paused;
      drain();
      write_reg(CSR_INTERVAL, iv);
      write_reg(CSR_OFFSET, off);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold) holds_asked++;
      generated = 0;
      paused = 1'b0;
      while (generated < PHASE_ITEMS) begin
         add_stream(n);
         generated += n;
         // The sender stops here until every snapshot so far has come back.
         if (pause_midway && !paused && generated >= PHASE_ITEMS / 2) begin
            paused = 1'b1;
            drain();
         end
      end
   endtask

   initial begin
      logic [STAMP_BITS-1:0] iv;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the register defaults: flush before any sample,
      // stamp zero, empty samples, the largest stamp and repeated flushes.
      offer(OP_FLUSH, 64'd0, 32'h0, 1'b0);
      offer(OP_SAMPLE, 64'd0, 32'hFFFF_FFFF, 1'b1);
      offer(OP_SAMPLE, 64'd1, 32'h1234_5678, 1'b0);
      offer(OP_SAMPLE, 64'd1000000000, 32'h0000_0001, 1'b1);
      offer(OP_SAMPLE, 64'd1000000001, 32'h8000_0000, 1'b1);
      offer(OP_SAMPLE, MAX_STAMP, 32'h0, 1'b1);
      offer(OP_FLUSH, MAX_STAMP, 32'hFFFF_FFFF, 1'b1);
      offer(OP_FLUSH, 64'd0, 32'h0, 1'b0);
      offer(OP_SAMPLE, MAX_STAMP, 32'hA5A5_A5A5, 1'b1);
      offer(OP_FLUSH, 64'd0, 32'h0, 1'b0);
      drain();

      // With an offset, a first sample can land past its own boundary and
      // emit the empty snapshot; an older stamp is simply held.
      write_reg(CSR_INTERVAL, 64'd1000);
      write_reg(CSR_OFFSET, 64'd2500);
      offer(OP_SAMPLE, 64'd10000, 32'h0000_0001, 1'b1);
      offer(OP_SAMPLE, 64'd10000, 32'h0000_0002, 1'b1);
      offer(OP_SAMPLE, 64'd5, 32'h0000_0003, 1'b1);
      offer(OP_SAMPLE, 64'd7999, 32'hFFFF_0000, 1'b0);
      offer(OP_SAMPLE, 64'd20000, 32'hFFFF_FFFF, 1'b1);
      offer(OP_FLUSH, 64'd0, 32'h0, 1'b0);
      offer(OP_SAMPLE, 64'd0, 32'h5A5A_5A5A, 1'b1);
      offer(OP_SAMPLE, 64'd1, 32'h0F0F_0F0F, 1'b1);
      offer(OP_SAMPLE, MAX_STAMP, 32'hF0F0_F0F0, 1'b1);
      offer(OP_FLUSH, MAX_STAMP, 32'hFFFF_FFFF, 1'b1);

      // Random streams over a range of grid settings and flow-control modes.
      run_phase(64'd1, 64'd0, 0, 0, 1'b0, 1'b0);
      run_phase(INTERVAL_RESET, {$urandom, $urandom}, 56, 0, 1'b0, 1'b0);
      run_phase('1, '1, 0, 56, 1'b0, 1'b0);
      run_phase($urandom_range(2, 5000), $urandom_range(10000), 12, 12, 1'b1, 1'b0);
      iv = {$urandom, $urandom};
      if (iv == '0) iv = 64'd1;
      run_phase(iv, {$urandom, $urandom}, 0, 0, 1'b0, 1'b0);
      run_phase($urandom_range(1, 32'hFFFF_FFFF), 64'd0, 56, 0, 1'b0, 1'b1);
      run_phase(64'd7, '1, 0, 56, 1'b0, 1'b0);
      run_phase($urandom_range(1, 1000000), {$urandom, $urandom}, 12, 12, 1'b1, 1'b0);
      drain();

      if (expected_snaps.size() != 0) begin
         $error("%0d snapshots never arrived", expected_snaps.size());
         mismatches++;
      end
      $display("Run covered %0d words and %0d checked snapshots over %0d register writes,",
               words_sent, snaps_checked, reg_writes);
      $display("including extreme grid settings, long result stalls and %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
